// ----- rtl/semaphore_bank_with_wait_queues_assert.svh -----
// Assertion macros used by the port-level checker of the semaphore bank.
`ifndef SEMAPHORE_BANK_WITH_WAIT_QUEUES_ASSERT_SVH
`define SEMAPHORE_BANK_WITH_WAIT_QUEUES_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SBWQ_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("semaphore bank check failed");

// Next-cycle implication, disabled during reset.
`define SBWQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("semaphore bank check failed");

`endif

// ----- rtl/sbwq_pkg.sv -----
// Package of types and constants for the semaphore bank.
package sbwq_pkg;

    localparam int DEF_NUM_SEMAPHORES = 16;
    localparam int DEF_QUEUE_DEPTH    = 1024;

    localparam int ID_W    = 4;
    localparam int COUNT_W = 16;
    localparam int REQ_W   = 16;

    typedef enum logic [1:0] {
        OP_CREATE  = 2'd0,
        OP_DESTROY = 2'd1,
        OP_ACQUIRE = 2'd2,
        OP_RELEASE = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FAULT = 2'd1,
        ST_LIMIT = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_WAKE,
        S_DONE
    } state_t;

endpackage

// ----- rtl/sbwq_req_if.sv -----
// Request channel interface of the semaphore bank.
interface sbwq_req_if;
    import sbwq_pkg::*;

    logic               valid;
    logic               ready;
    op_t                operation;
    logic [ID_W-1:0]    sem_id;
    logic [COUNT_W-1:0] initial_count;
    logic [REQ_W-1:0]   requester_id;

    modport source (output valid, operation, sem_id, initial_count, requester_id,
                    input ready);
    modport sink   (input valid, operation, sem_id, initial_count, requester_id,
                    output ready);
endinterface

// ----- rtl/sbwq_rsp_if.sv -----
// Response channel interface of the semaphore bank.
interface sbwq_rsp_if;
    import sbwq_pkg::*;

    logic             valid;
    logic             ready;
    status_t          status;
    logic             granted;
    logic [ID_W-1:0]  new_id;
    logic             woken_valid;
    logic [REQ_W-1:0] woken_id;

    modport source (output valid, status, granted, new_id, woken_valid, woken_id,
                    input ready);
    modport sink   (input valid, status, granted, new_id, woken_valid, woken_id,
                    output ready);
endinterface

// ----- rtl/sbwq_ram.sv -----
// Simple dual-port RAM with one write port and one registered read port.
module sbwq_ram #(
    parameter int DATA_W = 16,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);
    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

// ----- rtl/semaphore_bank_with_wait_queues.sv -----
// Top level of the semaphore bank: sequencer, record memory and wait queue memory.
//
// Usage: one request beat on req carries an operation (create, destroy, acquire,
// release), a semaphore id, an initial count and a requester id. Every request
// produces exactly one response beat on rsp with status, granted, new_id,
// woken_valid and woken_id; fields that do not apply to the operation are zero.
// Sequence: the record is read when the request beat is accepted, the operation
// executes on the read data and writes the record back, and the result then
// enters the output register. A release that wakes a waiter passes a wake state
// first, because the waiter's id is read from the wait queue memory after the
// record read. A new request waits for the read-modify-write of the per-semaphore
// record memory: its registered read, the write back and the response stage.
// A new request is accepted while an earlier response still waits on rsp; the
// sequencer then holds the finished response internally until the output
// register is taken, and accepts nothing further meanwhile.
// Reset clears the allocation bits, the id counter and the handshake state at
// once; no clearing pass runs. Record memory entries are rewritten by create
// before use, and wait queue entries are read only after being written.
module semaphore_bank_with_wait_queues #(
    parameter int NUM_SEMAPHORES = sbwq_pkg::DEF_NUM_SEMAPHORES,
    parameter int QUEUE_DEPTH    = sbwq_pkg::DEF_QUEUE_DEPTH
) (
    input  logic       clk,
    input  logic       rst_n,
    sbwq_req_if.sink   req,
    sbwq_rsp_if.source rsp
);
    import sbwq_pkg::*;

    // Widths that follow from the bank size and queue depth.
    localparam int SEM_W  = (NUM_SEMAPHORES > 1) ? $clog2(NUM_SEMAPHORES) : 1;
    localparam int POS_W  = $clog2(QUEUE_DEPTH);
    localparam int WCNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int QA_D   = NUM_SEMAPHORES * QUEUE_DEPTH;
    localparam int QA_W   = (QA_D > 1) ? $clog2(QA_D) : 1;
    localparam int SX_W   = ID_W + SEM_W;

    // Record layout: {max, available, waiter count, head, tail}.
    localparam int TAIL_LO = 0;
    localparam int HEAD_LO = POS_W;
    localparam int WCNT_LO = 2 * POS_W;
    localparam int AVL_LO  = WCNT_LO + WCNT_W;
    localparam int MAX_LO  = AVL_LO + COUNT_W;
    localparam int REC_W   = MAX_LO + COUNT_W;

    // Sequencer and latched request.
    state_t             state_reg, state_next;
    op_t                op_reg;
    logic [ID_W-1:0]    sid_reg;
    logic [COUNT_W-1:0] init_reg;
    logic [REQ_W-1:0]   req_id_reg;

    // Allocation bits and id counter live in flip-flops so reset clears them.
    logic [NUM_SEMAPHORES-1:0] alloc_reg, alloc_next;
    logic [SEM_W:0]            next_id_reg, next_id_next;

    // Staged result of the current operation.
    status_t          res_status_reg, res_status_next;
    logic             res_granted_reg, res_granted_next;
    logic [ID_W-1:0]  res_new_id_reg, res_new_id_next;
    logic             res_woken_valid_reg, res_woken_valid_next;
    logic [REQ_W-1:0] res_woken_id_reg;

    // Output register.
    logic             out_valid_reg;
    status_t          out_status_reg;
    logic             out_granted_reg;
    logic [ID_W-1:0]  out_new_id_reg;
    logic             out_woken_valid_reg;
    logic [REQ_W-1:0] out_woken_id_reg;

    // Memory ports.
    logic             rec_we, rec_re;
    logic [SEM_W-1:0] rec_waddr, rec_raddr;
    logic [REC_W-1:0] rec_wdata, rec_rdata;
    logic             q_we, q_re;
    logic [QA_W-1:0]  q_waddr, q_raddr;
    logic [REQ_W-1:0] q_wdata, q_rdata;

    // Decoded fields of the record read for the current operation.
    logic [COUNT_W-1:0] rec_max, rec_avl;
    logic [WCNT_W-1:0]  rec_wcnt;
    logic [POS_W-1:0]   rec_head, rec_tail;

    logic             accept, out_free, need_wake;
    logic [SX_W-1:0]  in_sid_ext, sid_ext;
    logic [SEM_W-1:0] in_slot, slot, create_slot;
    logic             sid_known;
    logic [SX_W:0]    next_id_ext;
    logic [POS_W-1:0] tail_adv, head_adv;
    logic [QA_W-1:0]  queue_base;

    assign accept   = req.valid && req.ready;
    assign out_free = !out_valid_reg || rsp.ready;

    assign in_sid_ext  = {{SEM_W{1'b0}}, req.sem_id};
    assign in_slot     = in_sid_ext[SEM_W-1:0];
    assign sid_ext     = {{SEM_W{1'b0}}, sid_reg};
    assign slot        = sid_ext[SEM_W-1:0];
    assign create_slot = next_id_reg[SEM_W-1:0];
    assign next_id_ext = {{ID_W{1'b0}}, next_id_reg};
    assign sid_known   = (sid_ext < SX_W'(NUM_SEMAPHORES)) && alloc_reg[slot];

    assign rec_max  = rec_rdata[MAX_LO +: COUNT_W];
    assign rec_avl  = rec_rdata[AVL_LO +: COUNT_W];
    assign rec_wcnt = rec_rdata[WCNT_LO +: WCNT_W];
    assign rec_head = rec_rdata[HEAD_LO +: POS_W];
    assign rec_tail = rec_rdata[TAIL_LO +: POS_W];

    // Circular queue pointers wrap at the queue depth, which need not be a power of two.
    assign tail_adv = (rec_tail == POS_W'(QUEUE_DEPTH - 1)) ? '0 : rec_tail + 1'b1;
    assign head_adv = (rec_head == POS_W'(QUEUE_DEPTH - 1)) ? '0 : rec_head + 1'b1;

    // Each semaphore owns a contiguous region of the wait queue memory.
    assign queue_base = QA_W'(slot) * QA_W'(QUEUE_DEPTH);

    sbwq_ram #(
        .DATA_W (REC_W),
        .DEPTH  (NUM_SEMAPHORES),
        .ADDR_W (SEM_W)
    ) u_rec_ram (
        .clk   (clk),
        .we    (rec_we),
        .waddr (rec_waddr),
        .wdata (rec_wdata),
        .re    (rec_re),
        .raddr (rec_raddr),
        .rdata (rec_rdata)
    );

    sbwq_ram #(
        .DATA_W (REQ_W),
        .DEPTH  (QA_D),
        .ADDR_W (QA_W)
    ) u_queue_ram (
        .clk   (clk),
        .we    (q_we),
        .waddr (q_waddr),
        .wdata (q_wdata),
        .re    (q_re),
        .raddr (q_raddr),
        .rdata (q_rdata)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = need_wake ? S_WAKE : S_DONE;
            end
            S_WAKE:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Outputs: memory accesses and the decision for the current operation.
    always_comb
    begin
        req.ready            = (state_reg == S_IDLE);
        rec_re               = accept;
        rec_raddr            = (req.operation == OP_CREATE) ? create_slot : in_slot;
        rec_we               = 1'b0;
        rec_waddr            = slot;
        rec_wdata            = rec_rdata;
        q_we                 = 1'b0;
        q_waddr              = queue_base + QA_W'(rec_tail);
        q_wdata              = req_id_reg;
        q_re                 = 1'b0;
        q_raddr              = queue_base + QA_W'(rec_head);
        need_wake            = 1'b0;
        alloc_next           = alloc_reg;
        next_id_next         = next_id_reg;
        res_status_next      = ST_OK;
        res_granted_next     = 1'b0;
        res_new_id_next      = '0;
        res_woken_valid_next = 1'b0;

        if (state_reg == S_EXEC)
        begin
            if (op_reg == OP_CREATE)
            begin
                if (next_id_reg >= (SEM_W + 1)'(NUM_SEMAPHORES))
                begin
                    res_status_next = ST_LIMIT;
                end
                else
                begin
                    rec_we                 = 1'b1;
                    rec_waddr              = create_slot;
                    rec_wdata              = '0;
                    rec_wdata[MAX_LO +: COUNT_W] = init_reg;
                    rec_wdata[AVL_LO +: COUNT_W] = init_reg;
                    alloc_next[create_slot] = 1'b1;
                    next_id_next           = next_id_reg + 1'b1;
                    res_new_id_next        = next_id_ext[ID_W-1:0];
                end
            end
            else if (!sid_known)
            begin
                res_status_next = ST_FAULT;
            end
            else
            begin
                case (op_reg)
                    OP_DESTROY:
                    begin
                        // Waiters are dropped; the id is never handed out again.
                        alloc_next[slot] = 1'b0;
                    end
                    OP_ACQUIRE:
                    begin
                        if (rec_avl != '0)
                        begin
                            rec_we                       = 1'b1;
                            rec_wdata[AVL_LO +: COUNT_W] = rec_avl - 1'b1;
                            res_granted_next             = 1'b1;
                        end
                        else if (rec_wcnt >= WCNT_W'(QUEUE_DEPTH))
                        begin
                            res_status_next = ST_LIMIT;
                        end
                        else
                        begin
                            q_we                          = 1'b1;
                            rec_we                        = 1'b1;
                            rec_wdata[TAIL_LO +: POS_W]   = tail_adv;
                            rec_wdata[WCNT_LO +: WCNT_W]  = rec_wcnt + 1'b1;
                        end
                    end
                    OP_RELEASE:
                    begin
                        if (rec_avl == rec_max)
                        begin
                            res_status_next = ST_LIMIT;
                        end
                        else if (rec_wcnt != '0)
                        begin
                            q_re                         = 1'b1;
                            need_wake                    = 1'b1;
                            res_woken_valid_next         = 1'b1;
                            rec_we                       = 1'b1;
                            rec_wdata[HEAD_LO +: POS_W]  = head_adv;
                            rec_wdata[WCNT_LO +: WCNT_W] = rec_wcnt - 1'b1;
                        end
                        else
                        begin
                            rec_we                       = 1'b1;
                            rec_wdata[AVL_LO +: COUNT_W] = rec_avl + 1'b1;
                        end
                    end
                    default:
                    begin
                        res_status_next = ST_FAULT;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            alloc_reg     <= '0;
            next_id_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            alloc_reg   <= alloc_next;
            next_id_reg <= next_id_next;
            if (state_reg == S_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg     <= req.operation;
            sid_reg    <= req.sem_id;
            init_reg   <= req.initial_count;
            req_id_reg <= req.requester_id;
        end
        if (state_reg == S_EXEC)
        begin
            res_status_reg      <= res_status_next;
            res_granted_reg     <= res_granted_next;
            res_new_id_reg      <= res_new_id_next;
            res_woken_valid_reg <= res_woken_valid_next;
            res_woken_id_reg    <= '0;
        end
        if (state_reg == S_WAKE)
        begin
            res_woken_id_reg <= q_rdata;
        end
        if (state_reg == S_DONE && out_free)
        begin
            out_status_reg      <= res_status_reg;
            out_granted_reg     <= res_granted_reg;
            out_new_id_reg      <= res_new_id_reg;
            out_woken_valid_reg <= res_woken_valid_reg;
            out_woken_id_reg    <= res_woken_id_reg;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.granted     = out_granted_reg;
    assign rsp.new_id      = out_new_id_reg;
    assign rsp.woken_valid = out_woken_valid_reg;
    assign rsp.woken_id    = out_woken_id_reg;
endmodule

// ----- rtl/sbwq_checker.sv -----
// Port-level checker for the semaphore bank and its bind statement.
`include "semaphore_bank_with_wait_queues_assert.svh"

module sbwq_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_ready,
    input logic                      out_valid,
    input logic                      out_ready,
    input sbwq_pkg::status_t         status,
    input logic                      granted,
    input logic [sbwq_pkg::ID_W-1:0] new_id,
    input logic                      woken_valid
);
    import sbwq_pkg::*;

    // A response beat that is not taken stays valid.
    `SBWQ_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)

    // One request is worked on at a time.
    `SBWQ_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)

    // An immediate grant and a wake-up are successes of different operations.
    `SBWQ_ASSERT_IMPLY(a_grant_ok, clk, rst_n, out_valid && granted,
                       status == ST_OK && !woken_valid && new_id == '0)
    `SBWQ_ASSERT_IMPLY(a_wake_ok, clk, rst_n, out_valid && woken_valid,
                       status == ST_OK && !granted && new_id == '0)

    // A failed operation reports nothing else.
    `SBWQ_ASSERT_IMPLY(a_fail_clean, clk, rst_n, out_valid && status != ST_OK,
                       !granted && !woken_valid && new_id == '0)
endmodule

bind semaphore_bank_with_wait_queues sbwq_checker u_sbwq_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (req.valid),
    .in_ready    (req.ready),
    .out_valid   (rsp.valid),
    .out_ready   (rsp.ready),
    .status      (rsp.status),
    .granted     (rsp.granted),
    .new_id      (rsp.new_id),
    .woken_valid (rsp.woken_valid)
);
